/* src/imu_cal_pkg.sv */
// Shared types, constants and scale-factor tables for the IMU affine calibration core.
// Depends on nothing; every other file in src imports it.
`default_nettype none

package imu_cal_pkg;

    localparam int LANES      = 3;
    localparam int CAL_SETS   = 4;
    localparam int SET_WORDS  = 12;
    localparam int ROW_WORDS  = 4;
    localparam int COEF_W     = 32;
    localparam int OUT_W      = 40;
    localparam int FACTOR_W   = 40;
    localparam int FLO_W      = 24;
    localparam int MAG_SHIFT  = 16;
    localparam int KIND_W     = 2;
    localparam int SET_W      = 2;
    localparam int WORD_W     = 2;
    localparam int SLOT_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int MAG_W      = 24;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_GYRO  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MAG   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    localparam logic [SET_W-1:0] SET_MAG_FINAL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALED        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RANGE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_RANGE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_PER_COUNT = 2'd3;

    localparam logic [MAG_W-1:0] MAG_PER_COUNT_RESET = 24'd2516582;

    localparam logic [WORD_W-1:0] WORD_OFFSET = 2'd0;

    typedef logic [ROW_WORDS-1:0][COEF_W-1:0] row_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              scaled;
        logic              clip;
    } ctl_t;

    typedef struct packed {
        logic              we;
        logic [SET_W-1:0]  set;
        logic [WORD_W-1:0] word;
        logic [COEF_W-1:0] data;
    } coef_wr_t;

    typedef struct packed {
        logic              hit;
        logic [1:0]        lane;
        logic [WORD_W-1:0] word;
    } slot_map_t;

    // Offsets go to word 0 of their axis lane; matrix row i goes to lane i, words 1..3.
    function automatic slot_map_t slot_decode(input logic [SLOT_W-1:0] slot);
        slot_map_t m;
        m = '0;
        case (slot)
            4'd0:    m = '{hit: 1'b1, lane: 2'd0, word: WORD_OFFSET};
            4'd1:    m = '{hit: 1'b1, lane: 2'd1, word: WORD_OFFSET};
            4'd2:    m = '{hit: 1'b1, lane: 2'd2, word: WORD_OFFSET};
            4'd3:    m = '{hit: 1'b1, lane: 2'd0, word: 2'd1};
            4'd4:    m = '{hit: 1'b1, lane: 2'd0, word: 2'd2};
            4'd5:    m = '{hit: 1'b1, lane: 2'd0, word: 2'd3};
            4'd6:    m = '{hit: 1'b1, lane: 2'd1, word: 2'd1};
            4'd7:    m = '{hit: 1'b1, lane: 2'd1, word: 2'd2};
            4'd8:    m = '{hit: 1'b1, lane: 2'd1, word: 2'd3};
            4'd9:    m = '{hit: 1'b1, lane: 2'd2, word: 2'd1};
            4'd10:   m = '{hit: 1'b1, lane: 2'd2, word: 2'd2};
            4'd11:   m = '{hit: 1'b1, lane: 2'd2, word: 2'd3};
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [FACTOR_W-1:0] gyro_factor(input logic [2:0] range_sel);
        logic [FACTOR_W-1:0] f;
        case (range_sel)
            3'd0:    f = 40'd4810363372;
            3'd1:    f = 40'd9620726743;
            3'd2:    f = 40'd19241453486;
            3'd3:    f = 40'd38482906972;
            3'd4:    f = 40'd76965813944;
            default: f = '0;
        endcase
        return f;
    endfunction

    function automatic logic [FACTOR_W-1:0] accel_factor(input logic [1:0] range_sel);
        logic [FACTOR_W-1:0] f;
        case (range_sel)
            2'd0:    f = 40'd67070209;
            2'd1:    f = 40'd134140419;
            2'd2:    f = 40'd268280837;
            2'd3:    f = 40'd536561674;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

/* src/imu_cal_in_if.sv */
// Input channel: valid/ready handshake with a coefficient-load or sample payload.
// Depends on imu_cal_pkg.
`default_nettype none

interface imu_cal_in_if #(
    parameter int RAW_BITS = 16
);
    import imu_cal_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [KIND_W-1:0]          sensor_kind;
    logic [SET_W-1:0]           coef_set;
    logic [SLOT_W-1:0]          coef_slot;
    logic signed [COEF_W-1:0]   coef_value;
    logic signed [RAW_BITS-1:0] raw_x;
    logic signed [RAW_BITS-1:0] raw_y;
    logic signed [RAW_BITS-1:0] raw_z;

    modport source (
        output valid, command, sensor_kind, coef_set, coef_slot, coef_value,
               raw_x, raw_y, raw_z,
        input  ready
    );

    modport sink (
        input  valid, command, sensor_kind, coef_set, coef_slot, coef_value,
               raw_x, raw_y, raw_z,
        output ready
    );
endinterface

`default_nettype wire

/* src/imu_cal_out_if.sv */
// Result channel: valid/ready handshake with a calibrated 3-axis result payload.
// Depends on imu_cal_pkg.
`default_nettype none

interface imu_cal_out_if;
    import imu_cal_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       result_kind;
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic signed [OUT_W-1:0] out_z;
    logic                    clipped;

    modport source (
        output valid, result_kind, out_x, out_y, out_z, clipped,
        input  ready
    );

    modport sink (
        input  valid, result_kind, out_x, out_y, out_z, clipped,
        output ready
    );
endinterface

`default_nettype wire

/* src/imu_affine_calibration_core.sv */
// IMU affine calibration core: three axis lanes, two matrix passes, remap merge.
// Coefficient loads produce no result and take effect for the next sample
// transaction. Throughput: one transaction per cycle while out_ch.ready holds,
// set by the elastic 11-stage pipeline.
// Reset clears stage valids, resets configuration; the coefficient store is
// undefined until loaded. Depends on imu_cal_pkg and the channel interfaces.
`default_nettype none

module imu_affine_calibration_core #(
    parameter int RAW_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    imu_cal_in_if.sink                                in_ch,
    imu_cal_out_if.source                             out_ch,
    input  wire logic                                 cfg_we,
    input  wire logic [imu_cal_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [imu_cal_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import imu_cal_pkg::*;

    localparam int NST = 11;
    localparam int SW  = RAW_BITS + 18;
    localparam int XW  = ((SW > OUT_W) ? SW : OUT_W) + 1;
    localparam int RW  = XW + 5;

    logic                 scaled_mode_reg;
    logic [1:0]           accel_range_reg;
    logic [2:0]           gyro_range_reg;
    logic [MAG_W-1:0]     mag_per_count_reg;

    logic [NST:1]         v_reg;
    logic [NST:1]         v_next;
    logic [NST+1:1]       ld;
    logic                 in_acc;
    logic                 sample_acc;
    logic                 load_acc;
    slot_map_t            smap;
    coef_wr_t             wr [LANES];
    logic [FACTOR_W-1:0]  factor;
    ctl_t                 ctl_reg [1:NST-1];
    ctl_t                 ctl7_next;

    logic signed [RAW_BITS-1:0] raw [LANES];
    row_t                       mem_a [LANES];
    row_t                       mem_b [LANES];
    row_t                       ca_reg [LANES][2:3];
    row_t                       cb_reg [LANES][2:7];
    logic signed [SW-1:0]       s [LANES];
    logic signed [SW-1:0]       s_reg [LANES][3:6];
    logic signed [XW-1:0]       x_next [LANES];
    logic signed [XW-1:0]       x_reg [LANES];
    logic signed [RW-1:0]       ra [LANES];
    logic signed [OUT_W-1:0]    mid [LANES];
    logic [LANES-1:0]           mid_clip;
    logic signed [XW-1:0]       x2_next [LANES];
    logic signed [XW-1:0]       x2_reg [LANES];
    logic signed [RW-1:0]       t_next [LANES];
    logic signed [RW-1:0]       t_reg [LANES][7:10];
    logic signed [RW-1:0]       r2 [LANES];

    assign raw[0] = in_ch.raw_x;
    assign raw[1] = in_ch.raw_y;
    assign raw[2] = in_ch.raw_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scaled_mode_reg   <= 1'b0;
            accel_range_reg   <= '0;
            gyro_range_reg    <= '0;
            mag_per_count_reg <= MAG_PER_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCALED:        scaled_mode_reg   <= cfg_data[0];
                CFG_ACCEL_RANGE:   accel_range_reg   <= cfg_data[1:0];
                CFG_GYRO_RANGE:    gyro_range_reg    <= cfg_data[2:0];
                CFG_MAG_PER_COUNT: mag_per_count_reg <= cfg_data[MAG_W-1:0];
                default:           scaled_mode_reg   <= scaled_mode_reg;
            endcase
        end
    end

    // advance a stage when it is empty or its successor advances
    always_comb
    begin
        ld[NST+1] = out_ch.ready;
        for (int k = NST; k >= 1; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    assign in_ch.ready = ld[1];
    assign in_acc      = in_ch.valid && ld[1];
    assign sample_acc  = in_acc && (in_ch.command == CMD_SAMPLE) &&
                         (in_ch.sensor_kind != KIND_NONE);
    assign load_acc    = in_acc && (in_ch.command == CMD_LOAD);
    assign smap        = slot_decode(in_ch.coef_slot);

    always_comb
    begin
        v_next = v_reg;
        if (ld[1])
        begin
            v_next[1] = sample_acc;
        end
        for (int k = 2; k <= NST; k++)
        begin
            if (ld[k])
            begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_comb
    begin
        case (in_ch.sensor_kind)
            KIND_GYRO:  factor = gyro_factor(gyro_range_reg);
            KIND_ACCEL: factor = accel_factor(accel_range_reg);
            KIND_MAG:   factor = {mag_per_count_reg, {MAG_SHIFT{1'b0}}};
            default:    factor = '0;
        endcase
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        assign wr[l] = '{we:   load_acc && smap.hit && (smap.lane == 2'(l)),
                         set:  in_ch.coef_set,
                         word: smap.word,
                         data: in_ch.coef_value};

        imu_cal_coef_mem u_mem (
            .clk    (clk),
            .wr     (wr[l]),
            .rd_en  (ld[1]),
            .rd_set (in_ch.sensor_kind),
            .rd_a   (mem_a[l]),
            .rd_b   (mem_b[l])
        );

        imu_cal_scale #(
            .RAW_BITS (RAW_BITS),
            .SW       (SW)
        ) u_scale (
            .clk    (clk),
            .ld     (ld[2:1]),
            .raw    (raw[l]),
            .factor (factor),
            .s      (s[l])
        );

        imu_cal_row #(
            .XW (XW),
            .RW (RW)
        ) u_row_a (
            .clk (clk),
            .ld  (ld[6:4]),
            .x   (x_reg),
            .m   (ca_reg[l][3][3:1]),
            .r   (ra[l])
        );

        imu_cal_row #(
            .XW (XW),
            .RW (RW)
        ) u_row_b (
            .clk (clk),
            .ld  (ld[10:8]),
            .x   (x2_reg),
            .m   (cb_reg[l][7][3:1]),
            .r   (r2[l])
        );
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            x_next[l] = XW'(s[l]) - XW'($signed(ca_reg[l][2][WORD_OFFSET]));
            if (!ra[l][RW-1] && (|ra[l][RW-2:OUT_W-1]))
            begin
                mid[l]      = {1'b0, {(OUT_W-1){1'b1}}};
                mid_clip[l] = 1'b1;
            end
            else if (ra[l][RW-1] && !(&ra[l][RW-2:OUT_W-1]))
            begin
                mid[l]      = {1'b1, {(OUT_W-1){1'b0}}};
                mid_clip[l] = 1'b1;
            end
            else
            begin
                mid[l]      = ra[l][OUT_W-1:0];
                mid_clip[l] = 1'b0;
            end
            x2_next[l] = XW'(mid[l]) - XW'($signed(cb_reg[l][6][WORD_OFFSET]));
            t_next[l]  = ctl_reg[6].scaled ? RW'(s_reg[l][6]) : ra[l];
        end
        ctl7_next      = ctl_reg[6];
        ctl7_next.clip = (|mid_clip) && (ctl_reg[6].kind == KIND_MAG) && !ctl_reg[6].scaled;
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            ctl_reg[1] <= '{kind: in_ch.sensor_kind, scaled: scaled_mode_reg, clip: 1'b0};
        end
        for (int k = 2; k <= NST-1; k++)
        begin
            if (ld[k])
            begin
                ctl_reg[k] <= (k == 7) ? ctl7_next : ctl_reg[k-1];
            end
        end
        for (int l = 0; l < LANES; l++)
        begin
            if (ld[2])
            begin
                ca_reg[l][2] <= mem_a[l];
                cb_reg[l][2] <= mem_b[l];
            end
            if (ld[3])
            begin
                ca_reg[l][3] <= ca_reg[l][2];
                x_reg[l]     <= x_next[l];
                s_reg[l][3]  <= s[l];
            end
            for (int k = 3; k <= 7; k++)
            begin
                if (ld[k])
                begin
                    cb_reg[l][k] <= cb_reg[l][k-1];
                end
            end
            for (int k = 4; k <= 6; k++)
            begin
                if (ld[k])
                begin
                    s_reg[l][k] <= s_reg[l][k-1];
                end
            end
            if (ld[7])
            begin
                x2_reg[l]   <= x2_next[l];
                t_reg[l][7] <= t_next[l];
            end
            for (int k = 8; k <= 10; k++)
            begin
                if (ld[k])
                begin
                    t_reg[l][k] <= t_reg[l][k-1];
                end
            end
        end
    end

    logic signed [RW-1:0] t_fin [LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            t_fin[l] = t_reg[l][10];
        end
    end

    imu_cal_merge #(
        .RW (RW)
    ) u_merge (
        .clk     (clk),
        .ld      (ld[NST]),
        .ctl     (ctl_reg[NST-1]),
        .t       (t_fin),
        .r2      (r2),
        .kind    (out_ch.result_kind),
        .o_x     (out_ch.out_x),
        .o_y     (out_ch.out_y),
        .o_z     (out_ch.out_z),
        .clipped (out_ch.clipped)
    );

    assign out_ch.valid = v_reg[NST];

    a_sample_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.command == CMD_SAMPLE &&
         in_ch.sensor_kind != KIND_NONE) |=> v_reg[1])
        else $error("accepted sample did not enter the pipeline");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        ((&v_reg) && !out_ch.ready) |-> !in_ch.ready)
        else $error("input taken while pipeline full and stalled");

    a_mid_clip_mag: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[7] && ctl_reg[7].clip) |->
        (ctl_reg[7].kind == KIND_MAG && !ctl_reg[7].scaled))
        else $error("intermediate clip flagged outside calibrated mag");

endmodule

`default_nettype wire

/* src/imu_cal_coef_mem.sv */
// Per-lane coefficient store: offset and matrix row for every calibration set.
// One write port, two registered read ports. Depends on imu_cal_pkg.
`default_nettype none

module imu_cal_coef_mem (
    input  wire logic                           clk,
    input  wire imu_cal_pkg::coef_wr_t          wr,
    input  wire logic                           rd_en,
    input  wire logic [imu_cal_pkg::SET_W-1:0]  rd_set,
    output imu_cal_pkg::row_t                   rd_a,
    output imu_cal_pkg::row_t                   rd_b
);
    import imu_cal_pkg::*;

    logic [COEF_W-1:0] mem [ROW_WORDS][CAL_SETS];
    row_t              rd_a_reg;
    row_t              rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.word][wr.set] <= wr.data;
        end
        if (rd_en)
        begin
            for (int w = 0; w < ROW_WORDS; w++)
            begin
                rd_a_reg[w] <= mem[w][rd_set];
                rd_b_reg[w] <= mem[w][SET_MAG_FINAL];
            end
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

`default_nettype wire

/* src/imu_cal_scale.sv */
// One axis lane of the count scaling: raw * per-count factor, rounded to Q.16.
// Two stages, factor split in two partial products. Depends on imu_cal_pkg.
`default_nettype none

module imu_cal_scale #(
    parameter int RAW_BITS = 16,
    parameter int SW       = 34
) (
    input  wire logic                                clk,
    input  wire logic [1:0]                          ld,
    input  wire logic signed [RAW_BITS-1:0]          raw,
    input  wire logic [imu_cal_pkg::FACTOR_W-1:0]    factor,
    output logic signed [SW-1:0]                     s
);
    import imu_cal_pkg::*;

    localparam int LW = RAW_BITS + FLO_W + 1;
    localparam int HW = RAW_BITS + FACTOR_W - FLO_W + 1;
    localparam logic signed [LW-1:0] RND = LW'(2**(FLO_W-1));

    logic signed [LW-1:0] p_lo_reg;
    logic signed [HW-1:0] p_hi_reg;
    logic signed [SW-1:0] s_reg;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            p_lo_reg <= LW'(raw) * LW'($signed({1'b0, factor[FLO_W-1:0]}));
            p_hi_reg <= HW'(raw) * HW'($signed({1'b0, factor[FACTOR_W-1:FLO_W]}));
        end
        if (ld[1])
        begin
            s_reg <= SW'(p_hi_reg) + SW'((p_lo_reg + RND) >>> FLO_W);
        end
    end

    assign s = s_reg;

endmodule

`default_nettype wire

/* src/imu_cal_row.sv */
// One matrix row of a calibration pass: three products split into high and
// low coefficient halves, summed and rounded to Q.16. Depends on imu_cal_pkg.
`default_nettype none

module imu_cal_row #(
    parameter int XW = 41,
    parameter int RW = 46
) (
    input  wire logic                                   clk,
    input  wire logic [2:0]                             ld,
    input  wire logic signed [XW-1:0]                   x [3],
    input  wire logic [2:0][imu_cal_pkg::COEF_W-1:0]    m,
    output logic signed [RW-1:0]                        r
);
    import imu_cal_pkg::*;

    localparam int PHW = XW + 16;
    localparam int PLW = XW + 17;
    localparam int AW  = XW + 18;
    localparam int BW  = XW + 19;
    localparam logic signed [BW-1:0] RND = BW'(2**29);

    logic signed [PHW-1:0] ph_reg [3];
    logic signed [PLW-1:0] pl_reg [3];
    logic signed [AW-1:0]  a_next;
    logic signed [BW-1:0]  b_sum;
    logic signed [AW-1:0]  a_reg;
    logic signed [BW-1:0]  bq_reg;
    logic signed [RW-1:0]  r_reg;

    always_comb
    begin
        a_next = '0;
        b_sum  = RND;
        for (int j = 0; j < 3; j++)
        begin
            a_next = a_next + AW'(ph_reg[j]);
            b_sum  = b_sum + BW'(pl_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            for (int j = 0; j < 3; j++)
            begin
                ph_reg[j] <= PHW'(x[j]) * PHW'($signed(m[j][COEF_W-1:16]));
                pl_reg[j] <= PLW'(x[j]) * PLW'($signed({1'b0, m[j][15:0]}));
            end
        end
        if (ld[1])
        begin
            a_reg  <= a_next;
            bq_reg <= b_sum >>> 16;
        end
        if (ld[2])
        begin
            r_reg <= RW'((BW'(a_reg) + bq_reg) >>> 14);
        end
    end

    assign r = r_reg;

endmodule

`default_nettype wire

/* src/imu_cal_merge.sv */
// Output stage: picks each lane's final value, remaps axes unless scaled,
// saturates to 40 bits and folds the lane clip flags. Depends on imu_cal_pkg.
`default_nettype none

module imu_cal_merge #(
    parameter int RW = 46
) (
    input  wire logic                                clk,
    input  wire logic                                ld,
    input  wire imu_cal_pkg::ctl_t                   ctl,
    input  wire logic signed [RW-1:0]                t [3],
    input  wire logic signed [RW-1:0]                r2 [3],
    output logic [imu_cal_pkg::KIND_W-1:0]           kind,
    output logic signed [imu_cal_pkg::OUT_W-1:0]     o_x,
    output logic signed [imu_cal_pkg::OUT_W-1:0]     o_y,
    output logic signed [imu_cal_pkg::OUT_W-1:0]     o_z,
    output logic                                     clipped
);
    import imu_cal_pkg::*;

    localparam int EW = RW + 1;

    logic signed [EW-1:0]    ext [3];
    logic signed [EW-1:0]    rm [3];
    logic signed [OUT_W-1:0] sat [3];
    logic                    clip_any;
    logic [KIND_W-1:0]       kind_reg;
    logic signed [OUT_W-1:0] o_reg [3];
    logic                    clip_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            ext[l] = (ctl.kind == KIND_MAG && !ctl.scaled) ? EW'(r2[l]) : EW'(t[l]);
            rm[l]  = ext[l];
        end
        if (!ctl.scaled)
        begin
            case (ctl.kind)
                KIND_GYRO:
                begin
                    rm[2] = -ext[2];
                end
                KIND_MAG:
                begin
                    rm[0] = -ext[1];
                    rm[1] = ext[0];
                    rm[2] = -ext[2];
                end
                default:
                begin
                    rm[0] = ext[0];
                end
            endcase
        end
        clip_any = ctl.clip;
        for (int l = 0; l < 3; l++)
        begin
            if (!rm[l][EW-1] && (|rm[l][EW-2:OUT_W-1]))
            begin
                sat[l]   = {1'b0, {(OUT_W-1){1'b1}}};
                clip_any = 1'b1;
            end
            else if (rm[l][EW-1] && !(&rm[l][EW-2:OUT_W-1]))
            begin
                sat[l]   = {1'b1, {(OUT_W-1){1'b0}}};
                clip_any = 1'b1;
            end
            else
            begin
                sat[l] = rm[l][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            kind_reg <= ctl.kind;
            clip_reg <= clip_any;
            for (int l = 0; l < 3; l++)
            begin
                o_reg[l] <= sat[l];
            end
        end
    end

    assign kind    = kind_reg;
    assign o_x     = o_reg[0];
    assign o_y     = o_reg[1];
    assign o_z     = o_reg[2];
    assign clipped = clip_reg;

endmodule

`default_nettype wire

/* test/imu_cal_tb_pkg.sv */
// Scoreboard class for the IMU affine calibration core testbench.
// Depends on imu_cal_pkg; holds its own predictor of the calibration arithmetic.
`timescale 1ns / 100ps

package imu_cal_tb_pkg;
    import imu_cal_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
        logic                    clip;
    } axis_result_t;

    class cal_scoreboard;
        logic [COEF_W-1:0]  coef_words [CAL_SETS*SET_WORDS];
        bit                 scaled;
        logic [1:0]         accel_sel;
        logic [2:0]         gyro_sel;
        logic [MAG_W-1:0]   mag_scale;
        axis_result_t       pending [$];
        int                 mismatches;

        function new();
            foreach (coef_words[i]) coef_words[i] = '0;
            scaled = 0;
            accel_sel = 0;
            gyro_sel = 0;
            mag_scale = MAG_PER_COUNT_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SCALED:        scaled = val[0];
                CFG_ACCEL_RANGE:   accel_sel = val[1:0];
                CFG_GYRO_RANGE:    gyro_sel = val[2:0];
                CFG_MAG_PER_COUNT: mag_scale = val[MAG_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, ref bit clip);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (OUT_W-1)) - 1;
            lo = -(longint'(1) <<< (OUT_W-1));
            if (v > hi) begin clip = 1; return hi; end
            if (v < lo) begin clip = 1; return lo; end
            return v;
        endfunction

        function void affine(int set, longint s[3], ref longint r[3]);
            longint d [3];
            longint m;
            longint acc_hi;
            longint acc_lo;
            for (int j = 0; j < 3; j++)
                d[j] = s[j] - longint'($signed(coef_words[set*SET_WORDS+j]));
            for (int i = 0; i < 3; i++)
            begin
                acc_hi = 0;
                acc_lo = 0;
                for (int j = 0; j < 3; j++)
                begin
                    m = longint'($signed(coef_words[set*SET_WORDS+3+3*i+j]));
                    acc_hi += d[j] * (m >>> 16);
                    acc_lo += d[j] * (m & 64'hFFFF);
                end
                r[i] = (acc_hi + ((acc_lo + (longint'(1) <<< 29)) >>> 16)) >>> 14;
            end
        endfunction

        function void note_input(logic cmd, logic [KIND_W-1:0] kind, logic [SET_W-1:0] set,
                                 logic [SLOT_W-1:0] slot, logic [COEF_W-1:0] value,
                                 longint rx, longint ry, longint rz);
            longint factor;
            longint s [3];
            longint v [3];
            longint t [3];
            longint raw [3];
            bit clip;
            axis_result_t r;
            if (cmd == CMD_LOAD)
            begin
                if (slot < SET_WORDS) coef_words[set*SET_WORDS+slot] = value;
                return;
            end
            if (kind == KIND_NONE) return;
            clip = 0;
            case (kind)
                KIND_GYRO:  factor = longint'(gyro_factor(gyro_sel));
                KIND_ACCEL: factor = longint'(accel_factor(accel_sel));
                default:    factor = longint'(mag_scale) <<< MAG_SHIFT;
            endcase
            raw[0] = rx; raw[1] = ry; raw[2] = rz;
            for (int i = 0; i < 3; i++)
                s[i] = (raw[i] * factor + (longint'(1) <<< 23)) >>> 24;
            if (scaled)
                v = s;
            else
            begin
                affine(kind, s, v);
                if (kind == KIND_MAG)
                begin
                    for (int i = 0; i < 3; i++) t[i] = clamp(v[i], clip);
                    affine(SET_MAG_FINAL, t, v);
                    t[0] = -v[1]; t[1] = v[0]; t[2] = -v[2];
                    v = t;
                end
                else if (kind == KIND_GYRO)
                    v[2] = -v[2];
            end
            for (int i = 0; i < 3; i++) v[i] = clamp(v[i], clip);
            r.kind = kind;
            r.x = v[0][OUT_W-1:0];
            r.y = v[1][OUT_W-1:0];
            r.z = v[2][OUT_W-1:0];
            r.clip = clip;
            pending.push_back(r);
        endfunction

        function void check_result(axis_result_t got);
            axis_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass
endpackage

/* test/testbench.sv */
// Top-level testbench: drives coefficient loads, samples and register writes
// into imu_affine_calibration_core and checks every result against the scoreboard.
`timescale 1ns / 100ps

module testbench;
    import imu_cal_pkg::*;
    import imu_cal_tb_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int send_gap;
    int stall_pct;
    bit run_done;

    imu_cal_in_if #(.RAW_BITS(16)) in_ch ();
    imu_cal_out_if out_ch ();
    cal_scoreboard board;

    imu_affine_calibration_core #(.RAW_BITS(16)) u_top (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            board.note_input(in_ch.command, in_ch.sensor_kind, in_ch.coef_set, in_ch.coef_slot,
                             in_ch.coef_value, longint'(in_ch.raw_x), longint'(in_ch.raw_y),
                             longint'(in_ch.raw_z));
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_result('{out_ch.result_kind, out_ch.out_x, out_ch.out_y,
                                 out_ch.out_z, out_ch.clipped});
    end

    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    task automatic send(logic cmd, logic [1:0] kind, logic [1:0] set, logic [3:0] slot,
                        logic [31:0] value, logic [15:0] rx, logic [15:0] ry, logic [15:0] rz);
        if ($urandom_range(99) < send_gap)
        begin
            in_ch.valid <= 0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        in_ch.valid <= 1;
        in_ch.command <= cmd;
        in_ch.sensor_kind <= kind;
        in_ch.coef_set <= set;
        in_ch.coef_slot <= slot;
        in_ch.coef_value <= value;
        in_ch.raw_x <= rx;
        in_ch.raw_y <= ry;
        in_ch.raw_z <= rz;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load(logic [1:0] set, logic [3:0] slot, logic [31:0] value);
        send(CMD_LOAD, KIND_GYRO, set, slot, value, $urandom, $urandom, $urandom);
    endtask

    task automatic sample(logic [1:0] kind, logic [15:0] rx, logic [15:0] ry, logic [15:0] rz);
        send(CMD_SAMPLE, kind, $urandom, $urandom, $urandom, rx, ry, rz);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        @(negedge clk);
        while (board.pending.size() != 0) @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        board.set_reg(idx, val);
        @(negedge clk);
        cfg_we <= 0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coef(int slot);
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return $urandom;
            default: return slot < 3 ? $signed($urandom_range(2000000)) - 1000000
                                     : $signed($urandom_range(1 << 31)) - (1 << 30);
        endcase
    endfunction

    function automatic logic [15:0] rand_raw();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic load_all();
        for (int set = 0; set < CAL_SETS; set++)
            for (int slot = 0; slot < SET_WORDS; slot++)
                load(set, slot, rand_coef(slot));
    endtask

    task automatic random_phase(int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 8)
                load($urandom, $urandom_range(15), rand_coef($urandom_range(11)));
            else if (r < 10)
                sample(KIND_NONE, $urandom, $urandom, $urandom);
            else
                sample($urandom_range(2), rand_raw(), rand_raw(), rand_raw());
        end
        drain();
    endtask

    task automatic set_regs(bit sc, logic [1:0] ar, logic [2:0] gr, logic [23:0] mag);
        write_reg(CFG_SCALED, sc);
        write_reg(CFG_ACCEL_RANGE, ar);
        write_reg(CFG_GYRO_RANGE, gr);
        write_reg(CFG_MAG_PER_COUNT, mag);
    endtask

    initial
    begin
        board = new();
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 0;
        in_ch.command = CMD_LOAD;
        in_ch.sensor_kind = '0;
        in_ch.coef_set = '0;
        in_ch.coef_slot = '0;
        in_ch.coef_value = '0;
        in_ch.raw_x = '0;
        in_ch.raw_y = '0;
        in_ch.raw_z = '0;
        out_ch.ready = 0;
        send_gap = 10;
        stall_pct = 63;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        load_all();
        load(0, 12, 32'h1234_5678);
        load(0, 15, 32'hFFFF_FFFF);
        sample(KIND_GYRO, 16'h7FFF, 16'h8000, 16'h0000);
        sample(KIND_ACCEL, 16'h8000, 16'h7FFF, 16'hFFFF);
        sample(KIND_MAG, 16'h8000, 16'h8000, 16'h7FFF);
        sample(KIND_NONE, 16'h1111, 16'h2222, 16'h3333);
        for (int s = 0; s < CAL_SETS; s++)
        begin
            load(s, 0, 32'h7FFF_FFFF);
            load(s, 3, 32'h8000_0000);
            load(s, 7, 32'h8000_0000);
            load(s, 11, 32'h8000_0000);
        end
        sample(KIND_MAG, 16'h8000, 16'h8000, 16'h8000);
        sample(KIND_GYRO, 16'h8000, 16'h8000, 16'h8000);
        drain();

        set_regs(1, 3, 4, 24'hFFFFFF);
        sample(KIND_GYRO, 16'h8000, 16'h7FFF, 16'h0001);
        sample(KIND_ACCEL, 16'h8000, 16'h7FFF, 16'h0001);
        sample(KIND_MAG, 16'h8000, 16'h7FFF, 16'h0001);
        drain();
        set_regs(1, 0, 7, 24'h000000);
        sample(KIND_GYRO, 16'h7FFF, 16'h8000, 16'h1234);
        sample(KIND_MAG, 16'h7FFF, 16'h8000, 16'h1234);
        drain();

        for (int p = 0; p < 9; p++)
        begin
            if (p == 3) begin send_gap = 63; stall_pct = 10; end
            if (p == 6) begin send_gap = 0; stall_pct = 0; end
            set_regs($urandom_range(1), $urandom_range(3), $urandom_range(7), $urandom);
            load_all();
            random_phase(35);
        end

        $display("");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

/* files.f */
src/imu_cal_pkg.sv
src/imu_cal_in_if.sv
src/imu_cal_out_if.sv
src/imu_cal_coef_mem.sv
src/imu_cal_scale.sv
src/imu_cal_row.sv
src/imu_cal_merge.sv
src/imu_affine_calibration_core.sv
test/imu_cal_tb_pkg.sv
test/testbench.sv
